[rtl/core/dual_wheel_pid_speed_control_assert.svh]
// Assertion macros shared by the wheel regulator RTL.
// Expects clk and rst_n in the scope of use.
`ifndef DUAL_WHEEL_PID_SPEED_CONTROL_ASSERT_SVH
`define DUAL_WHEEL_PID_SPEED_CONTROL_ASSERT_SVH

// condition that must hold at every edge out of reset
`define DWPID_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// same-cycle implication
`define DWPID_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/core/dwpid_pkg.sv]
// Package for the dual wheel PID regulator: widths, codes, FSM and command types.
// No dependencies.
package dwpid_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int DRIVE_W    = 18;
  localparam int SPEED_W    = 32;
  localparam int GAIN_W     = 24;
  localparam int LIM_W      = 17;
  localparam int GATE_W     = 16;
  localparam int TIME_W     = 32;
  localparam int TICK_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int PROD_W     = 56;
  localparam int CMD_W      = 39;
  localparam int DER_MAG_W  = 42;
  localparam int DIV_REM_W  = 32;
  localparam int DIV_DVD_W  = 48;
  localparam int DIV_CNT_W  = 6;
  localparam logic [DIV_CNT_W-1:0] SPD_STEPS = 6'd32;
  localparam logic [DIV_CNT_W-1:0] DER_STEPS = 6'd42;
  localparam logic [36:0] TERM_CAP = 37'h10_0000_0000;
  localparam int DRIVE_ONE = 1 << FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GAIN_P, REG_GAIN_I, REG_GAIN_D, REG_ACCEL,
    REG_DECEL, REG_CM_TICK, REG_MAX_SPEED, REG_GATE
  } reg_idx_t;

  localparam logic [1:0] TERM_P = 2'd0;
  localparam logic [1:0] TERM_I = 2'd1;
  localparam logic [1:0] TERM_D = 2'd2;

  typedef enum logic [4:0] {
    ST_IDLE, ST_LOAD, ST_CHECK, ST_SMUL, ST_SSCALE, ST_SDIV_LD, ST_SDIV,
    ST_ERR, ST_INT, ST_DDIV, ST_DER, ST_GLO, ST_GHI, ST_GACC, ST_DRV,
    ST_TGT, ST_OUT
  } state_t;

  typedef enum logic [3:0] {
    ACT_NONE, ACT_ACCEPT, ACT_LOAD, ACT_SMUL, ACT_SSCALE, ACT_SDIV_LD,
    ACT_ERR, ACT_INT, ACT_DER, ACT_GLO, ACT_GHI, ACT_GACC, ACT_DRV,
    ACT_TGT, ACT_OUT
  } act_t;

  typedef struct packed {
    act_t       act;
    logic [1:0] term;
  } dp_cmd_t;

  typedef struct packed {
    logic op;
    logic go;
    logic ovf;
    logic div_busy;
    logic out_free;
  } dp_sts_t;

endpackage

[rtl/core/dwpid_if.sv]
// Valid/ready channel interfaces for sample words and result words.
// Depends on dwpid_pkg.
interface dwpid_in_if import dwpid_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic                     channel;
  logic [TIME_W-1:0]        now_ms;
  logic signed [TICK_W-1:0] tick_delta;
  logic signed [TICK_W-1:0] target_fraction;

  modport source(output valid, op, channel, now_ms, tick_delta, target_fraction,
                 input ready);
  modport sink(input valid, op, channel, now_ms, tick_delta, target_fraction,
               output ready);
endinterface

interface dwpid_out_if import dwpid_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic                      out_channel;
  logic                      updated;
  logic signed [DRIVE_W-1:0] drive;
  logic signed [SPEED_W-1:0] measured_speed;

  modport source(output valid, out_channel, updated, drive, measured_speed,
                 input ready);
  modport sink(input valid, out_channel, updated, drive, measured_speed,
               output ready);
endinterface

[rtl/core/dwpid_div.sv]
// Restoring divider, one quotient bit per cycle, shared by speed and derivative.
// Depends on dwpid_pkg and the assertion macro header.
`include "dual_wheel_pid_speed_control_assert.svh"
module dwpid_div import dwpid_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [DIV_REM_W-1:0] init_rem,
  input  logic [DIV_DVD_W-1:0] init_dvd,
  input  logic [DIV_CNT_W-1:0] steps,
  input  logic [DIV_REM_W-1:0] divisor,
  output logic                 busy,
  output logic [DIV_DVD_W-1:0] quo
);

  logic                 busy_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DIV_REM_W-1:0] rem_r;
  logic [DIV_DVD_W-1:0] dvd_r;
  logic [DIV_REM_W:0]   rem_sh;
  logic [DIV_REM_W:0]   rem_sub;
  logic                 ge;

  assign rem_sh  = {rem_r, dvd_r[DIV_DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_sub = rem_sh - {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= steps;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == 1) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= init_rem;
      dvd_r <= init_dvd;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[DIV_REM_W-1:0] : rem_sh[DIV_REM_W-1:0];
      dvd_r <= {dvd_r[DIV_DVD_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quo  = dvd_r;

  `DWPID_ASSERT_IMPL(a_div_cnt, busy_r, cnt_r != 0, "divider busy with zero count")

endmodule

[rtl/core/dwpid_dp.sv]
// Datapath: config registers, per-wheel state, shared multiplier, divider, output reg.
// Depends on dwpid_pkg, dwpid_div and the assertion macro header.
`include "dual_wheel_pid_speed_control_assert.svh"
module dwpid_dp import dwpid_pkg::*; #(
  parameter int INTEGRAL_WIDTH = 48
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  dp_cmd_t                      cmd,
  output dp_sts_t                      sts,
  input  logic                         in_op,
  input  logic                         in_channel,
  input  logic [TIME_W-1:0]            in_now_ms,
  input  logic signed [TICK_W-1:0]     in_tick_delta,
  input  logic signed [TICK_W-1:0]     in_target_fraction,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_idx,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         out_ready,
  output logic                         out_valid,
  output logic                         out_channel,
  output logic                         out_updated,
  output logic signed [DRIVE_W-1:0]    out_drive,
  output logic signed [SPEED_W-1:0]    out_measured_speed
);

  localparam int IW   = INTEGRAL_WIDTH;
  localparam int MAGW = (IW > DER_MAG_W) ? IW : DER_MAG_W;
  localparam int HIW  = MAGW - 32;
  localparam int ACCW = MAGW + GAIN_W;
  localparam int TW   = ACCW - FRAC_BITS;

  // config
  logic [GAIN_W-1:0] gain_p_r, gain_i_r, gain_d_r, cm_r, max_r;
  logic [LIM_W-1:0]  accel_r, decel_r;
  logic [GATE_W-1:0] gate_r;

  // per-wheel state
  logic signed [SPEED_W-1:0] target_r [2];
  logic signed [SPEED_W-1:0] speed_r  [2];
  logic signed [IW-1:0]      esum_r   [2];
  logic signed [SPEED_W-1:0] lerr_r   [2];
  logic [TIME_W-1:0]         lupd_r   [2];
  logic signed [DRIVE_W-1:0] drive_r  [2];
  logic signed [31:0]        cnt_r    [2];

  // captured word
  logic                     op_r, ch_r;
  logic [TIME_W-1:0]        now_r;
  logic signed [TICK_W-1:0] tick_r, frac_r;

  // work registers
  logic [TIME_W-1:0]         el_r;
  logic                      go_r, upd_r, dneg_r, neg_r;
  logic [PROD_W-1:0]         p_r;
  logic [64:0]               d_r;
  logic signed [SPEED_W-1:0] spd_new_r, err_new_r;
  logic signed [IW-1:0]      esum_new_r;
  logic signed [DER_MAG_W:0] der_r;
  logic [HIW-1:0]            mag_hi_r;
  logic [ACCW-1:0]           acc_r;
  logic signed [CMD_W-1:0]   cmd_r;

  logic                      out_valid_r, out_ch_r, out_upd_r;
  logic signed [DRIVE_W-1:0] out_drive_r;
  logic signed [SPEED_W-1:0] out_spd_r;

  // combinational
  logic [31:0]          mul_a;
  logic [GAIN_W-1:0]    mul_b, gain_sel;
  logic [PROD_W-1:0]    prod;
  logic signed [31:0]   cs;
  logic [31:0]          cnt_mag;
  logic [15:0]          frac_mag;
  logic [TIME_W-1:0]    el_now, gate_eff;
  logic [32:0]          cnt_sum;
  logic [31:0]          cnt_sat;
  logic                 ovf, big;
  logic [31:0]          q, spd_nxt, err_nxt;
  logic [32:0]          ediff;
  logic [IW:0]          esum_sum;
  logic [IW-1:0]        esum_nxt;
  logic [32:0]          dd;
  logic [31:0]          dmag;
  logic [DER_MAG_W-1:0] dm;
  logic [DER_MAG_W:0]   qx;
  logic signed [MAGW:0] vsel;
  logic [MAGW-1:0]      vmag;
  logic [TW-1:0]        t;
  logic [36:0]          tcap;
  logic [CMD_W-1:0]     tsig;
  logic signed [CMD_W-1:0] acc_lim, dec_lim, cmdc;
  logic signed [DRIVE_W:0] dsum;
  logic signed [DRIVE_W-1:0] drv_nxt;
  logic [24:0]          tt;
  logic [31:0]          tgt;
  logic                 div_start, div_busy;
  logic [DIV_REM_W-1:0] div_rem;
  logic [DIV_DVD_W-1:0] div_dvd, div_quo;
  logic [DIV_CNT_W-1:0] div_steps;
  logic                 drv_ok;

  assign cs       = cnt_r[ch_r];
  assign cnt_mag  = cs[31] ? (~cs + 32'd1) : cs;
  assign frac_mag = frac_r[15] ? (~frac_r + 16'd1) : frac_r;
  assign gate_eff = (gate_r == '0) ? 32'd1 : 32'(gate_r);
  assign el_now   = now_r - lupd_r[ch_r];
  assign cnt_sum  = {cs[31], cs} + {{17{tick_r[15]}}, tick_r};
  assign cnt_sat  = (cnt_sum[32] != cnt_sum[31]) ?
                    (cnt_sum[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : cnt_sum[31:0];

  always_comb begin
    unique case (cmd.term)
      TERM_P:  gain_sel = gain_p_r;
      TERM_I:  gain_sel = gain_i_r;
      TERM_D:  gain_sel = gain_d_r;
      default: gain_sel = '0;
    endcase
    unique case (cmd.term)
      TERM_P:  vsel = (MAGW+1)'(err_new_r);
      TERM_I:  vsel = (MAGW+1)'(esum_new_r);
      TERM_D:  vsel = (MAGW+1)'(der_r);
      default: vsel = '0;
    endcase
  end

  assign vmag = vsel[MAGW] ? MAGW'(-vsel) : MAGW'(vsel);

  always_comb begin
    unique case (cmd.act)
      ACT_SMUL: begin
        mul_a = cnt_mag;
        mul_b = cm_r;
      end
      ACT_TGT: begin
        mul_a = 32'(frac_mag);
        mul_b = max_r;
      end
      ACT_GLO: begin
        mul_a = vmag[31:0];
        mul_b = gain_sel;
      end
      ACT_GHI: begin
        mul_a = 32'(mag_hi_r);
        mul_b = gain_sel;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = mul_a * mul_b;

  // speed = |count| * cm * 1000 / elapsed
  assign ovf     = d_r[64:32] >= {1'b0, el_r};
  assign q       = div_quo[31:0];
  assign big     = ovf | q[31];
  assign spd_nxt = cs[31] ? (big ? 32'h8000_0000 : (~q + 32'd1))
                          : (big ? 32'h7FFF_FFFF : q);
  assign ediff   = {target_r[ch_r][31], target_r[ch_r]} - {spd_nxt[31], spd_nxt};
  assign err_nxt = (ediff[32] != ediff[31]) ?
                   (ediff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : ediff[31:0];

  assign esum_sum = (IW+1)'(esum_r[ch_r]) + (IW+1)'(err_new_r);
  assign esum_nxt = (esum_sum[IW] != esum_sum[IW-1]) ?
                    {esum_sum[IW], {(IW-1){~esum_sum[IW]}}} : esum_sum[IW-1:0];

  assign dd   = {err_new_r[31], err_new_r} - {lerr_r[ch_r][31], lerr_r[ch_r]};
  assign dmag = dd[32] ? 32'(~dd + 33'd1) : dd[31:0];
  assign dm   = (DER_MAG_W'(dmag) << 10) - (DER_MAG_W'(dmag) << 4)
              - (DER_MAG_W'(dmag) << 3);
  assign qx   = {1'b0, div_quo[DER_MAG_W-1:0]};

  assign t    = acc_r[ACCW-1:FRAC_BITS];
  assign tcap = (t > TW'(TERM_CAP)) ? TERM_CAP : t[36:0];
  assign tsig = CMD_W'(tcap);

  assign acc_lim = $signed(CMD_W'(accel_r));
  assign dec_lim = $signed(CMD_W'(decel_r));
  assign cmdc    = (cmd_r < -dec_lim) ? -dec_lim : ((cmd_r > acc_lim) ? acc_lim : cmd_r);
  assign dsum    = (DRIVE_W+1)'(drive_r[ch_r]) + (DRIVE_W+1)'(cmdc);
  assign drv_nxt = (dsum > $signed((DRIVE_W+1)'(DRIVE_ONE))) ? DRIVE_W'(DRIVE_ONE) :
                   ((dsum < -$signed((DRIVE_W+1)'(DRIVE_ONE))) ? -DRIVE_W'(DRIVE_ONE)
                                                              : dsum[DRIVE_W-1:0]);

  assign tt  = prod[39:15];
  assign tgt = frac_r[15] ? (~32'(tt) + 32'd1) : 32'(tt);

  always_comb begin
    div_start = 1'b0;
    div_rem   = '0;
    div_dvd   = '0;
    div_steps = SPD_STEPS;
    if (cmd.act == ACT_SDIV_LD) begin
      div_start = !ovf;
      div_rem   = d_r[63:32];
      div_dvd   = {d_r[31:0], 16'b0};
    end else if (cmd.act == ACT_INT) begin
      div_start = 1'b1;
      div_dvd   = {dm, 6'b0};
      div_steps = DER_STEPS;
    end
  end

  dwpid_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .init_rem (div_rem),
    .init_dvd (div_dvd),
    .steps    (div_steps),
    .divisor  (el_r),
    .busy     (div_busy),
    .quo      (div_quo)
  );

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_p_r <= 24'd65536;
      gain_i_r <= '0;
      gain_d_r <= '0;
      accel_r  <= 17'd6554;
      decel_r  <= 17'd6554;
      cm_r     <= 24'd1500;
      max_r    <= 24'd3276800;
      gate_r   <= 16'd125;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_idx))
        REG_GAIN_P:    gain_p_r <= cfg_wdata;
        REG_GAIN_I:    gain_i_r <= cfg_wdata;
        REG_GAIN_D:    gain_d_r <= cfg_wdata;
        REG_ACCEL:     accel_r  <= cfg_wdata[LIM_W-1:0];
        REG_DECEL:     decel_r  <= cfg_wdata[LIM_W-1:0];
        REG_CM_TICK:   cm_r     <= cfg_wdata;
        REG_MAX_SPEED: max_r    <= cfg_wdata;
        REG_GATE:      gate_r   <= cfg_wdata[GATE_W-1:0];
      endcase
    end
  end

  // per-wheel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 2; i++) begin
        target_r[i] <= '0;
        speed_r[i]  <= '0;
        esum_r[i]   <= '0;
        lerr_r[i]   <= '0;
        lupd_r[i]   <= '0;
        drive_r[i]  <= '0;
        cnt_r[i]    <= '0;
      end
    end else begin
      if (cmd.act == ACT_LOAD) begin
        cnt_r[ch_r] <= cnt_sat;
      end else if (cmd.act == ACT_TGT) begin
        target_r[ch_r] <= tgt;
        speed_r[ch_r]  <= '0;
        esum_r[ch_r]   <= '0;
        lerr_r[ch_r]   <= '0;
        lupd_r[ch_r]   <= '0;
        cnt_r[ch_r]    <= '0;
      end else if (cmd.act == ACT_DRV) begin
        drive_r[ch_r] <= drv_nxt;
        speed_r[ch_r] <= spd_new_r;
        esum_r[ch_r]  <= esum_new_r;
        lerr_r[ch_r]  <= err_new_r;
        lupd_r[ch_r]  <= now_r;
        cnt_r[ch_r]   <= '0;
      end
    end
  end

  // work registers
  always_ff @(posedge clk) begin
    unique case (cmd.act)
      ACT_ACCEPT: begin
        op_r   <= in_op;
        ch_r   <= in_channel;
        now_r  <= in_now_ms;
        tick_r <= in_tick_delta;
        frac_r <= in_target_fraction;
        upd_r  <= 1'b0;
      end
      ACT_LOAD: begin
        el_r <= el_now;
        go_r <= el_now >= gate_eff;
      end
      ACT_SMUL:   p_r <= prod;
      ACT_SSCALE: d_r <= (65'(p_r) << 10) - (65'(p_r) << 4) - (65'(p_r) << 3);
      ACT_ERR: begin
        spd_new_r <= spd_nxt;
        err_new_r <= err_nxt;
      end
      ACT_INT: begin
        esum_new_r <= esum_nxt;
        dneg_r     <= dd[32];
      end
      ACT_DER: begin
        der_r <= dneg_r ? (~qx + 1'b1) : qx;
        cmd_r <= '0;
      end
      ACT_GLO: begin
        acc_r    <= ACCW'(prod);
        mag_hi_r <= vmag[MAGW-1:32];
        neg_r    <= vsel[MAGW];
      end
      ACT_GHI:  acc_r <= acc_r + (ACCW'(prod) << 32);
      ACT_GACC: cmd_r <= neg_r ? (cmd_r - tsig) : (cmd_r + tsig);
      ACT_DRV:  upd_r <= 1'b1;
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.act == ACT_OUT) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.act == ACT_OUT) begin
      out_ch_r    <= ch_r;
      out_upd_r   <= upd_r;
      out_drive_r <= drive_r[ch_r];
      out_spd_r   <= speed_r[ch_r];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_channel        = out_ch_r;
  assign out_updated        = out_upd_r;
  assign out_drive          = out_drive_r;
  assign out_measured_speed = out_spd_r;

  assign sts.op       = op_r;
  assign sts.go       = go_r;
  assign sts.ovf      = ovf;
  assign sts.div_busy = div_busy;
  assign sts.out_free = !out_valid_r || out_ready;

  assign drv_ok = (drive_r[0] <= $signed(DRIVE_W'(DRIVE_ONE)))
               && (drive_r[0] >= -$signed(DRIVE_W'(DRIVE_ONE)))
               && (drive_r[1] <= $signed(DRIVE_W'(DRIVE_ONE)))
               && (drive_r[1] >= -$signed(DRIVE_W'(DRIVE_ONE)));

  `DWPID_ASSERT(a_drive_rng, drv_ok, "drive level out of range")

endmodule

[rtl/core/dwpid_ctrl.sv]
// Controller FSM: sequences the datapath steps for sample and target words.
// Depends on dwpid_pkg and the assertion macro header.
`include "dual_wheel_pid_speed_control_assert.svh"
module dwpid_ctrl import dwpid_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] term_r, term_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      term_r  <= TERM_P;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    unique case (state_r)
      ST_IDLE:    if (in_valid) state_nxt = ST_LOAD;
      ST_LOAD:    state_nxt = sts.op ? ST_TGT : ST_CHECK;
      ST_CHECK:   state_nxt = sts.go ? ST_SMUL : ST_OUT;
      ST_SMUL:    state_nxt = ST_SSCALE;
      ST_SSCALE:  state_nxt = ST_SDIV_LD;
      ST_SDIV_LD: state_nxt = sts.ovf ? ST_ERR : ST_SDIV;
      ST_SDIV:    if (!sts.div_busy) state_nxt = ST_ERR;
      ST_ERR:     state_nxt = ST_INT;
      ST_INT:     state_nxt = ST_DDIV;
      ST_DDIV:    if (!sts.div_busy) state_nxt = ST_DER;
      ST_DER: begin
        state_nxt = ST_GLO;
        term_nxt  = TERM_P;
      end
      ST_GLO:     state_nxt = ST_GHI;
      ST_GHI:     state_nxt = ST_GACC;
      ST_GACC: begin
        if (term_r == TERM_D) begin
          state_nxt = ST_DRV;
        end else begin
          state_nxt = ST_GLO;
          term_nxt  = term_r + 2'd1;
        end
      end
      ST_DRV:     state_nxt = ST_OUT;
      ST_TGT:     state_nxt = ST_OUT;
      ST_OUT:     if (sts.out_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.term = term_r;
    cmd.act  = ACT_NONE;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.act = ACT_ACCEPT;
      end
      ST_LOAD:    cmd.act = sts.op ? ACT_NONE : ACT_LOAD;
      ST_SMUL:    cmd.act = ACT_SMUL;
      ST_SSCALE:  cmd.act = ACT_SSCALE;
      ST_SDIV_LD: cmd.act = ACT_SDIV_LD;
      ST_ERR:     cmd.act = ACT_ERR;
      ST_INT:     cmd.act = ACT_INT;
      ST_DER:     cmd.act = ACT_DER;
      ST_GLO:     cmd.act = ACT_GLO;
      ST_GHI:     cmd.act = ACT_GHI;
      ST_GACC:    cmd.act = ACT_GACC;
      ST_DRV:     cmd.act = ACT_DRV;
      ST_TGT:     cmd.act = ACT_TGT;
      ST_OUT:     if (sts.out_free) cmd.act = ACT_OUT;
      default:    cmd.act = ACT_NONE;
    endcase
  end

  `DWPID_ASSERT_IMPL(a_idle_div, state_r == ST_IDLE, !sts.div_busy, "divider busy while idle")
  `DWPID_ASSERT_IMPL(a_gacc_seq, state_r == ST_GACC, $past(state_r) == ST_GHI, "gain step out of order")
  `DWPID_ASSERT(a_term_rng, term_r <= TERM_D, "gain term index out of range")

endmodule

[rtl/core/dual_wheel_pid_speed_control.sv]
// Top level of the two-wheel PID speed regulator.
// Depends on dwpid_pkg, dwpid_if, dwpid_ctrl and dwpid_dp.
//
//   port       dir   kind            holds
//   in_chan    in    valid/ready     op, channel, now_ms, tick_delta, target_fraction
//   out_chan   out   valid/ready     out_channel, updated, drive, measured_speed
//   cfg_*      in    write strobe    register index and value
//
// Target words and samples inside the gate skip the divider and gain steps.
// A regulator update runs through the one-bit-per-cycle divider (32 steps for
// speed, 42 for the derivative) and the shared 32x24 multiplier.
// Reset is synchronous, active low; all wheel state clears at once.
// One word is in flight; in_ready is high while idle even if a result waits.
module dual_wheel_pid_speed_control import dwpid_pkg::*; #(
  parameter int INTEGRAL_WIDTH = 48
) (
  input  logic                  clk,
  input  logic                  rst_n,
  dwpid_in_if.sink              in_chan,
  dwpid_out_if.source           out_chan,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  dwpid_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  dwpid_dp #(
    .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .in_op              (in_chan.op),
    .in_channel         (in_chan.channel),
    .in_now_ms          (in_chan.now_ms),
    .in_tick_delta      (in_chan.tick_delta),
    .in_target_fraction (in_chan.target_fraction),
    .cfg_we             (cfg_we),
    .cfg_idx            (cfg_idx),
    .cfg_wdata          (cfg_wdata),
    .out_ready          (out_chan.ready),
    .out_valid          (out_chan.valid),
    .out_channel        (out_chan.out_channel),
    .out_updated        (out_chan.updated),
    .out_drive          (out_chan.drive),
    .out_measured_speed (out_chan.measured_speed)
  );

endmodule

[bench/dual_wheel_pid_speed_control_tb.sv]
// Self-checking testbench for the two-wheel PID speed regulator.
// Depends on dwpid_pkg, dwpid_if and dual_wheel_pid_speed_control; a scoreboard
// class predicts each result word and compares it with the block's output.
module dual_wheel_pid_speed_control_tb;
  import dwpid_pkg::*;

  typedef struct {
    bit               op;
    bit               ch;
    bit [31:0]        now;
    bit signed [15:0] ticks;
    bit signed [15:0] frac;
  } sample_word_t;

  typedef struct {
    bit                      ch;
    bit                      upd;
    bit signed [DRIVE_W-1:0] drive;
    bit signed [SPEED_W-1:0] speed;
  } wheel_result_t;

  class wheel_scoreboard;
    longint unsigned gain_p, gain_i, gain_d, accel, decel, cm_tick, max_spd, gate;
    longint target_speed[2], last_speed[2], error_sum[2], last_error[2];
    longint drive_level[2], count_sum[2];
    bit [31:0] last_ms[2];
    wheel_result_t expected_q[$];
    int errors;

    function new();
      gain_p = 65536; gain_i = 0; gain_d = 0; accel = 6554; decel = 6554;
      cm_tick = 1500; max_spd = 3276800; gate = 125;
      for (int c = 0; c < 2; c++) begin
        target_speed[c] = 0; last_speed[c] = 0; error_sum[c] = 0;
        last_error[c] = 0; drive_level[c] = 0; count_sum[c] = 0; last_ms[c] = 0;
      end
      errors = 0;
    endfunction

    function void set_reg(reg_idx_t idx, bit [23:0] v);
      case (idx)
        REG_GAIN_P:    gain_p = v;
        REG_GAIN_I:    gain_i = v;
        REG_GAIN_D:    gain_d = v;
        REG_ACCEL:     accel = v[16:0];
        REG_DECEL:     decel = v[16:0];
        REG_CM_TICK:   cm_tick = v;
        REG_MAX_SPEED: max_spd = v;
        REG_GATE:      gate = v[15:0];
        default: ;
      endcase
    endfunction

    function longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint unsigned mag(longint v);
      return v < 0 ? longint'(0) - v : v;
    endfunction

    function longint scaled_term(longint unsigned g, longint v);
      longint unsigned m, r;
      m = mag(v);
      if (g != 0 && m > (64'd1 << 52) / g) r = 64'd1 << 36;
      else r = (g * m) >> FRAC_BITS;
      return v < 0 ? -longint'(r) : longint'(r);
    endfunction

    function void note_input(sample_word_t w);
      longint unsigned t, p, q, r, el, smag, gt;
      longint speed, err, deriv, cmd, imax, imin;
      wheel_result_t res;
      int c;
      c = w.ch;
      res.upd = 0;
      if (w.op) begin
        t = (mag(longint'(w.frac)) * max_spd) >> 15;
        error_sum[c] = 0; last_error[c] = 0; last_ms[c] = 0;
        last_speed[c] = 0; count_sum[c] = 0;
        target_speed[c] = clamp(w.frac < 0 ? -longint'(t) : longint'(t),
                                -(64'sd1 << 31), (64'sd1 << 31) - 1);
      end else begin
        gt = gate == 0 ? 1 : gate;
        count_sum[c] = clamp(count_sum[c] + longint'(w.ticks),
                             -(64'sd1 << 31), (64'sd1 << 31) - 1);
        el = {32'd0, w.now - last_ms[c]};
        if (el >= gt) begin
          imax = (64'sd1 <<< 47) - 1;
          imin = -imax - 1;
          p = mag(count_sum[c]) * cm_tick;
          q = p / el; r = p % el;
          if (q > 64'hFFFF_FFFF) smag = 64'hFFFF_FFFF * 1000;
          else smag = q * 1000 + (r * 1000) / el;
          if (count_sum[c] < 0)
            speed = smag >= 64'h8000_0000 ? -(64'sd1 << 31) : -longint'(smag);
          else
            speed = smag > 64'h7FFF_FFFF ? (64'sd1 << 31) - 1 : longint'(smag);
          err = clamp(target_speed[c] - speed, -(64'sd1 << 31), (64'sd1 << 31) - 1);
          if (err > 0 && error_sum[c] > imax - err) error_sum[c] = imax;
          else if (err < 0 && error_sum[c] < imin - err) error_sum[c] = imin;
          else error_sum[c] += err;
          deriv = ((err - last_error[c]) * 1000) / longint'(el);
          cmd = scaled_term(gain_p, err) + scaled_term(gain_i, error_sum[c])
              + scaled_term(gain_d, deriv);
          cmd = clamp(cmd, -longint'(decel), longint'(accel));
          drive_level[c] = clamp(drive_level[c] + cmd, -65536, 65536);
          last_speed[c] = speed;
          last_error[c] = err;
          last_ms[c] = w.now;
          count_sum[c] = 0;
          res.upd = 1;
        end
      end
      res.ch = w.ch;
      res.drive = drive_level[c][DRIVE_W-1:0];
      res.speed = last_speed[c][SPEED_W-1:0];
      expected_q.push_back(res);
    endfunction

    function void check_result(wheel_result_t a);
      wheel_result_t e;
      if (expected_q.size() == 0) begin
        $display("%0t unexpected word: ch %0d upd %0d drive %0d speed %0d",
                 $time, a.ch, a.upd, a.drive, a.speed);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (a.ch != e.ch) begin
        $display("%0t channel: expected %0d actual %0d", $time, e.ch, a.ch);
        errors++;
      end
      if (a.upd != e.upd) begin
        $display("%0t updated: expected %0d actual %0d", $time, e.upd, a.upd);
        errors++;
      end
      if (a.drive != e.drive) begin
        $display("%0t drive: expected %0d actual %0d", $time, e.drive, a.drive);
        errors++;
      end
      if (a.speed != e.speed) begin
        $display("%0t speed: expected %0d actual %0d", $time, e.speed, a.speed);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  dwpid_in_if in_if ();
  dwpid_out_if out_if ();

  dual_wheel_pid_speed_control DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  wheel_scoreboard sb = new();
  bit steady;
  int hold_cycles;
  bit [31:0] wheel_ms[2];

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #12_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // result side: random back-pressure, plus a long hold on request
  initial begin
    wheel_result_t a;
    out_if.ready = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        a.ch = out_if.out_channel;
        a.upd = out_if.updated;
        a.drive = out_if.drive;
        a.speed = out_if.measured_speed;
        sb.check_result(a);
      end
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_if.ready <= 0;
      end else begin
        out_if.ready <= steady ? 1'b1 : ($urandom_range(99) >= 15);
      end
    end
  end

  task send_word(sample_word_t w);
    if (!steady && $urandom_range(99) < 15) begin
      in_if.valid <= 0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_if.op <= w.op;
    in_if.channel <= w.ch;
    in_if.now_ms <= w.now;
    in_if.tick_delta <= w.ticks;
    in_if.target_fraction <= w.frac;
    in_if.valid <= 1;
    do @(posedge clk); while (!in_if.ready);
    sb.note_input(w);
    if (!w.op) wheel_ms[w.ch] = w.now;
    else wheel_ms[w.ch] = 0;
  endtask

  task send_fields(bit op, bit ch, bit [31:0] now, bit [15:0] ticks, bit [15:0] frac);
    sample_word_t w;
    w.op = op; w.ch = ch; w.now = now; w.ticks = ticks; w.frac = frac;
    send_word(w);
  endtask

  task wait_idle();
    in_if.valid <= 0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task write_reg(reg_idx_t idx, bit [23:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
  endtask

  task end_writes();
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task random_word(int ngate);
    sample_word_t w;
    int unsigned k;
    w.ch = 1'($urandom_range(1));
    w.op = $urandom_range(99) < 8;
    k = $urandom_range(99);
    w.frac = k < 10 ? 16'sh7FFF : (k < 20 ? 16'sh8000 : 16'($urandom));
    if ($urandom_range(99) < 5) w.now = $urandom;
    else w.now = wheel_ms[w.ch] + $urandom_range(0, 2 * ngate + 2);
    k = $urandom_range(99);
    if (k < 60) w.ticks = 16'($signed($urandom_range(0, 400)) - 200);
    else w.ticks = 16'($urandom);
    send_word(w);
  endtask

  task random_phase(int n, int ngate);
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) hold_cycles = 400;
      steady = (i >= n / 2 && i < n / 2 + 30);
      random_word(ngate);
    end
    steady = 0;
  endtask

  initial begin
    rst_n = 0;
    cfg_we = 0; cfg_idx = '0; cfg_wdata = '0;
    in_if.valid = 0; in_if.op = 0; in_if.channel = 0;
    in_if.now_ms = '0; in_if.tick_delta = '0; in_if.target_fraction = '0;
    steady = 0; hold_cycles = 0;
    wheel_ms[0] = 0; wheel_ms[1] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: extremes, wrap, no-update, target reset
    send_fields(1, 0, 32'd0, 16'h7FFF, 16'h7FFF);
    send_fields(1, 1, 32'd0, 16'h8000, 16'h8000);
    send_fields(0, 0, 32'd200, 16'd100, 16'd0);
    send_fields(0, 0, 32'd210, 16'd50, 16'd0);
    send_fields(0, 1, 32'hFFFF_FFFF, 16'h8000, 16'd0);
    send_fields(0, 1, 32'd200, 16'h7FFF, 16'd0);
    send_fields(0, 0, 32'd400, 16'h8000, 16'd0);
    send_fields(1, 0, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
    send_fields(0, 0, 32'd0, 16'd0, 16'd0);
    send_fields(0, 0, 32'd125, 16'd0, 16'd0);

    wait_idle();
    write_reg(REG_GATE, 24'd0);
    write_reg(REG_GAIN_P, 24'hFFFFFF);
    write_reg(REG_GAIN_I, 24'hFFFFFF);
    write_reg(REG_GAIN_D, 24'hFFFFFF);
    write_reg(REG_ACCEL, 24'h1FFFF);
    write_reg(REG_DECEL, 24'd65536);
    write_reg(REG_CM_TICK, 24'hFFFFFF);
    write_reg(REG_MAX_SPEED, 24'hFFFFFF);
    end_writes();
    send_fields(1, 1, 32'd5, 16'd0, 16'h7FFF);
    send_fields(0, 1, 32'd0, 16'd3, 16'd0);
    send_fields(0, 1, 32'd0, 16'd3, 16'd0);
    send_fields(0, 1, 32'd1, 16'h8000, 16'd0);
    send_fields(0, 1, 32'd2, 16'h7FFF, 16'd0);
    send_fields(0, 1, 32'd2, 16'd0, 16'd0);

    // long gate, steady burst of large counts
    wait_idle();
    write_reg(REG_GATE, 24'hFFFF);
    write_reg(REG_ACCEL, 24'd0);
    write_reg(REG_DECEL, 24'd0);
    end_writes();
    send_fields(1, 0, 32'd0, 16'd0, 16'h4000);
    steady = 1;
    for (int i = 0; i < 20; i++) send_fields(0, 0, 32'd1, 16'h7FFF, 16'd0);
    send_fields(0, 0, 32'd70000, 16'd1, 16'd0);
    steady = 0;
    random_phase(120, 65535);

    for (int ph = 0; ph < 6; ph++) begin
      wait_idle();
      write_reg(REG_GAIN_P, ph == 5 ? 24'd0 : 24'($urandom_range(0, 24'h3FFFF)));
      write_reg(REG_GAIN_I, ph == 5 ? 24'hFFFFFF : 24'($urandom_range(0, 24'h1FFFF)));
      write_reg(REG_GAIN_D, ph == 5 ? 24'd0 : 24'($urandom_range(0, 24'hFFFF)));
      write_reg(REG_ACCEL, ph == 4 ? 24'd65536 : 24'($urandom_range(0, 24'h1FFFF)));
      write_reg(REG_DECEL, ph == 4 ? 24'h1FFFF : 24'($urandom_range(0, 24'h1FFFF)));
      write_reg(REG_CM_TICK, ph == 3 ? 24'd0 : 24'($urandom));
      write_reg(REG_MAX_SPEED, ph == 3 ? 24'd0 : 24'($urandom));
      write_reg(REG_GATE, 24'($urandom_range(1, 20)));
      end_writes();
      random_phase(120, int'(sb.gate));
    end

    wait_idle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      if (sb.expected_q.size() != 0)
        $display("%0t %0d words never arrived", $time, sb.expected_q.size());
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
